### rtl/dzsm_pkg.sv
// Package for the zoned disk sector mapper: item types, zone constants and
// the small lookup functions shared by the pipeline and the divider.
// Depends on nothing.
package dzsm_pkg;

  // One input item.
  typedef struct packed {
    logic       command;
    logic [7:0] track_in;
    logic [7:0] sector_in;
    logic [9:0] block_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       out_valid;
    logic [9:0] block_number;
    logic [5:0] found_track;
    logic [4:0] found_sector;
    logic [1:0] speed_zone;
    logic [4:0] sectors_in_track;
    logic       next_valid;
    logic [5:0] next_track;
    logic [4:0] next_sector;
  } out_item_t;

  // Commands.
  localparam logic CMD_LINK   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  // Speed zones.
  localparam logic [1:0] ZONE_17 = 2'd0;
  localparam logic [1:0] ZONE_18 = 2'd1;
  localparam logic [1:0] ZONE_19 = 2'd2;
  localparam logic [1:0] ZONE_21 = 2'd3;

  // Last track of each zone and the directory track.
  localparam logic [7:0] LAST_TRACK_Z3 = 8'd17;
  localparam logic [7:0] LAST_TRACK_Z2 = 8'd24;
  localparam logic [7:0] LAST_TRACK_Z1 = 8'd30;
  localparam logic [5:0] DIR_TRACK     = 6'd18;
  localparam logic [5:0] SKIP_FROM     = 6'd17;
  localparam logic [5:0] SKIP_TO       = 6'd19;

  // Blocks in front of the first track of each zone.
  localparam logic [9:0] BASE_Z2 = 10'd357;
  localparam logic [9:0] BASE_Z1 = 10'd490;
  localparam logic [9:0] BASE_Z0 = 10'd598;

  // Reset value of the track count register.
  localparam logic [5:0] NUM_TRACKS_RST = 6'd35;

  // Zone of a track counted from 1.
  function automatic logic [1:0] zone_of(input logic [7:0] t);
    logic [1:0] z;
    if (t <= LAST_TRACK_Z3) begin
      z = ZONE_21;
    end else if (t <= LAST_TRACK_Z2) begin
      z = ZONE_19;
    end else if (t <= LAST_TRACK_Z1) begin
      z = ZONE_18;
    end else begin
      z = ZONE_17;
    end
    return z;
  endfunction

  // Sectors per track of a zone.
  function automatic logic [4:0] zone_sectors(input logic [1:0] z);
    logic [4:0] n;
    unique case (z)
      ZONE_21: n = 5'd21;
      ZONE_19: n = 5'd19;
      ZONE_18: n = 5'd18;
      ZONE_17: n = 5'd17;
    endcase
    return n;
  endfunction

  // Rounded-up 2^16 / sectors, used to divide by the zone's sector count.
  function automatic logic [11:0] zone_recip(input logic [1:0] z);
    logic [11:0] m;
    unique case (z)
      ZONE_21: m = 12'd3121;
      ZONE_19: m = 12'd3450;
      ZONE_18: m = 12'd3641;
      ZONE_17: m = 12'd3856;
    endcase
    return m;
  endfunction

  // First track of a zone.
  function automatic logic [5:0] zone_first_track(input logic [1:0] z);
    logic [5:0] t;
    unique case (z)
      ZONE_21: t = 6'd1;
      ZONE_19: t = 6'd18;
      ZONE_18: t = 6'd25;
      ZONE_17: t = 6'd31;
    endcase
    return t;
  endfunction

  // Blocks that precede track t (t counted from 1; 0 gives 0).
  function automatic logic [9:0] blocks_before(input logic [5:0] t);
    logic [9:0] tt;
    logic [9:0] b;
    tt = {4'b0, t};
    if (t == 6'd0) begin
      b = 10'd0;
    end else if (tt <= 10'(LAST_TRACK_Z3)) begin
      b = 10'd21 * (tt - 10'd1);
    end else if (tt <= 10'(LAST_TRACK_Z2)) begin
      b = BASE_Z2 + 10'd19 * (tt - 10'd18);
    end else if (tt <= 10'(LAST_TRACK_Z1)) begin
      b = BASE_Z1 + 10'd18 * (tt - 10'd25);
    end else begin
      b = BASE_Z0 + 10'd17 * (tt - 10'd31);
    end
    return b;
  endfunction

  // Interleave step on the directory track: (s + 3) mod 19.
  function automatic logic [4:0] dir_next(input logic [4:0] s);
    logic [5:0] sum;
    sum = {1'b0, s} + 6'd3;
    if (sum >= 6'd19) begin
      sum = sum - 6'd19;
    end
    return sum[4:0];
  endfunction

  // Interleave step on the 18-sector tracks.
  function automatic logic [4:0] zone1_next(input logic [4:0] s);
    logic [4:0] n;
    unique case (s)
      5'd0:    n = 5'd10;
      5'd1:    n = 5'd11;
      5'd2:    n = 5'd12;
      5'd3:    n = 5'd13;
      5'd4:    n = 5'd14;
      5'd5:    n = 5'd15;
      5'd6:    n = 5'd16;
      5'd7:    n = 5'd17;
      5'd8:    n = 5'd1;
      5'd9:    n = 5'd0;
      5'd10:   n = 5'd2;
      5'd11:   n = 5'd3;
      5'd12:   n = 5'd4;
      5'd13:   n = 5'd5;
      5'd14:   n = 5'd6;
      5'd15:   n = 5'd7;
      5'd16:   n = 5'd8;
      5'd17:   n = 5'd9;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/dzsm_div.sv
// Three-stage divider of a zone offset by the zone's sector count.
// Depends on dzsm_pkg for the reciprocal and sector count tables.
module dzsm_div (
  input  logic       clk,
  input  logic       en,
  input  logic [8:0] r_i,
  input  logic [1:0] zone_i,
  output logic [4:0] q_o,
  output logic [4:0] rem_o
);

  logic [8:0]  r_a_r;
  logic [1:0]  z_a_r;
  logic [8:0]  r_b_r;
  logic [4:0]  d_b_r;
  logic [4:0]  qe_b_r;
  logic [4:0]  q_c_r;
  logic [4:0]  rem_c_r;

  logic [20:0] prod;
  logic [9:0]  qd;
  logic [10:0] diff;
  logic [10:0] diff_fix;
  logic [4:0]  q_nxt;
  logic [4:0]  rem_nxt;

  // Quotient estimate by reciprocal multiplication; never below the true value.
  assign prod = 21'(r_a_r) * 21'(dzsm_pkg::zone_recip(z_a_r));

  // Remainder with one correction step when the estimate was one too high.
  assign qd       = 10'(qe_b_r) * 10'(d_b_r);
  assign diff     = {2'b0, r_b_r} - {1'b0, qd};
  assign diff_fix = diff + {6'b0, d_b_r};
  assign q_nxt    = diff[10] ? (qe_b_r - 5'd1) : qe_b_r;
  assign rem_nxt  = diff[10] ? diff_fix[4:0] : diff[4:0];

  // Stage registers, advanced together with the main pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      r_a_r   <= r_i;
      z_a_r   <= zone_i;
      r_b_r   <= r_a_r;
      d_b_r   <= dzsm_pkg::zone_sectors(z_a_r);
      qe_b_r  <= prod[20:16];
      q_c_r   <= q_nxt;
      rem_c_r <= rem_nxt;
    end
  end

  assign q_o   = q_c_r;
  assign rem_o = rem_c_r;

endmodule

### rtl/disk_zone_sector_mapper_core.sv
// Top level of the zoned disk sector mapper: link resolution and block lookup.
// Depends on dzsm_pkg and dzsm_div.
//
// Each item passes three register stages: stage 1, stage 2 and the output
// register, which holds the result that is shown on the output.
// One item is taken every cycle as long as the result side takes results.
// The whole pipeline advances on a single enable that holds while the output
// register is full and out_ready is low, so the output register bounds
// throughput to out_ready's rate. Command 0 checks a track and sector link
// and returns its block number, zone, sector count and next interleave link;
// command 1 returns the track and sector of a block.
// Register 0 (byte address 0) holds the track count; values above
// MAX_TRACKS act as MAX_TRACKS.
module disk_zone_sector_mapper_core #(
  parameter int MAX_TRACKS = 42
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dzsm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dzsm_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [5:0] MAX_TR = 6'(MAX_TRACKS);

  logic [5:0] num_tracks_r;
  logic [5:0] tracks;
  logic       en;

  // Stage 1 registers.
  logic       v1_r;
  logic       cmd1_r;
  logic       ok1_r;
  logic       inr1_r;
  logic [5:0] t1_r;
  logic [4:0] s1_r;
  logic [1:0] z1_r;
  logic [4:0] n1_r;
  logic [9:0] cum1_r;
  logic [5:0] tr1_r;
  logic [1:0] zb1_r;

  // Stage 2 registers.
  logic       v2_r;
  logic       cmd2_r;
  logic       ok2_r;
  logic       inr2_r;
  logic [9:0] blk2_r;
  logic [1:0] z2_r;
  logic [4:0] n2_r;
  logic       nv2_r;
  logic [5:0] nt2_r;
  logic [4:0] ns2_r;
  logic [1:0] zb2_r;

  // Output stage registers.
  logic                v3_r;
  logic                inr3_r;
  logic [1:0]          zb3_r;
  dzsm_pkg::out_item_t res3_r;
  dzsm_pkg::out_item_t res3_nxt;

  // Stage 1 combinational signals.
  logic [1:0] zone_t;
  logic [4:0] n_t;
  logic       t_on;
  logic       link_ok;
  logic [9:0] total;
  logic [1:0] zone_b;
  logic [9:0] off_b;
  logic [9:0] r_b;

  // Stage 2 combinational signals.
  logic [9:0] blk;
  logic [5:0] s_plus;
  logic [4:0] ns;
  logic [5:0] nt;
  logic       nv;

  logic [4:0] q;
  logic [4:0] rem;

  // Configuration register; the write completes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tracks_r <= dzsm_pkg::NUM_TRACKS_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      num_tracks_r <= pwdata[5:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {26'd0, num_tracks_r};
  assign tracks = (num_tracks_r > MAX_TR) ? MAX_TR : num_tracks_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign en       = !v3_r || out_ready;
  assign in_ready = en;

  // Stage 1: zone, sector count and range checks of the incoming item.
  assign zone_t  = dzsm_pkg::zone_of(in_data.track_in);
  assign n_t     = dzsm_pkg::zone_sectors(zone_t);
  assign t_on    = (in_data.track_in != 8'd0) && (in_data.track_in <= {2'b0, tracks});
  assign link_ok = (in_data.command == dzsm_pkg::CMD_LINK) && t_on &&
                   (in_data.sector_in < {3'b0, n_t});
  assign total   = dzsm_pkg::blocks_before(tracks + 6'd1);

  // Zone of a block number and its offset into that zone.
  always_comb begin
    if (in_data.block_in < dzsm_pkg::BASE_Z2) begin
      zone_b = dzsm_pkg::ZONE_21;
      off_b  = 10'd0;
    end else if (in_data.block_in < dzsm_pkg::BASE_Z1) begin
      zone_b = dzsm_pkg::ZONE_19;
      off_b  = dzsm_pkg::BASE_Z2;
    end else if (in_data.block_in < dzsm_pkg::BASE_Z0) begin
      zone_b = dzsm_pkg::ZONE_18;
      off_b  = dzsm_pkg::BASE_Z1;
    end else begin
      zone_b = dzsm_pkg::ZONE_17;
      off_b  = dzsm_pkg::BASE_Z0;
    end
  end
  assign r_b = in_data.block_in - off_b;

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= in_data.command;
      ok1_r  <= link_ok;
      inr1_r <= (in_data.command == dzsm_pkg::CMD_LOCATE) && (in_data.block_in < total);
      t1_r   <= in_data.track_in[5:0];
      s1_r   <= in_data.sector_in[4:0];
      z1_r   <= zone_t;
      n1_r   <= n_t;
      cum1_r <= dzsm_pkg::blocks_before(in_data.track_in[5:0]);
      tr1_r  <= tracks;
      zb1_r  <= zone_b;
    end
  end

  // Stage 2: block number and the next link of the interleave chain.
  assign blk    = cum1_r + {5'b0, s1_r};
  assign s_plus = {1'b0, s1_r} + 6'd10;

  always_comb begin
    nt = t1_r;
    nv = 1'b1;
    if (t1_r == dzsm_pkg::DIR_TRACK) begin
      ns = dzsm_pkg::dir_next(s1_r);
      nv = (ns != 5'd0);
    end else begin
      if (z1_r == dzsm_pkg::ZONE_18) begin
        ns = dzsm_pkg::zone1_next(s1_r);
      end else if (s_plus >= {1'b0, n1_r}) begin
        ns = 5'(s_plus - {1'b0, n1_r});
      end else begin
        ns = s_plus[4:0];
      end
      // A wrap moves to the next track, stepping over the directory track.
      if (ns == 5'd0) begin
        if (t1_r >= tr1_r) begin
          nv = 1'b0;
        end else begin
          nt = (t1_r == dzsm_pkg::SKIP_FROM) ? dzsm_pkg::SKIP_TO : (t1_r + 6'd1);
          nv = (nt <= tr1_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r <= cmd1_r;
      ok2_r  <= ok1_r;
      inr2_r <= inr1_r;
      blk2_r <= blk;
      z2_r   <= z1_r;
      n2_r   <= n1_r;
      nv2_r  <= nv;
      nt2_r  <= nt;
      ns2_r  <= ns;
      zb2_r  <= zb1_r;
    end
  end

  // Stage 3: zero every field that the command or a failed check leaves open.
  always_comb begin
    res3_nxt = '0;
    if (cmd2_r == dzsm_pkg::CMD_LOCATE) begin
      res3_nxt.out_valid = inr2_r;
    end else if (ok2_r) begin
      res3_nxt.out_valid        = 1'b1;
      res3_nxt.block_number     = blk2_r;
      res3_nxt.speed_zone       = z2_r;
      res3_nxt.sectors_in_track = n2_r;
      res3_nxt.next_valid       = nv2_r;
      res3_nxt.next_track       = nv2_r ? nt2_r : 6'd0;
      res3_nxt.next_sector      = nv2_r ? ns2_r : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res3_r <= res3_nxt;
      inr3_r <= inr2_r;
      zb3_r  <= zb2_r;
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Track and sector of a block: quotient and remainder within its zone.
  dzsm_div u_div (
    .clk    (clk),
    .en     (en),
    .r_i    (r_b[8:0]),
    .zone_i (zone_b),
    .q_o    (q),
    .rem_o  (rem)
  );

  // Result item.
  always_comb begin
    out_data              = res3_r;
    out_data.found_track  = inr3_r ? (dzsm_pkg::zone_first_track(zb3_r) + {1'b0, q}) : 6'd0;
    out_data.found_sector = inr3_r ? rem : 5'd0;
  end

  assign out_valid = v3_r;

endmodule

### rtl/dzsm_check.sv
// Port-level checks for the zoned disk sector mapper, bound to its top level.
// Depends on dzsm_pkg and disk_zone_sector_mapper_core.
module dzsm_check (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input dzsm_pkg::out_item_t out_data
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A failed link or an out-of-range block carries only zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_valid |-> out_data == '0)
    else $error("invalid result item has nonzero fields");

  // A next link only follows a valid link.
  a_next_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.next_valid |->
      out_data.out_valid && out_data.sectors_in_track != 5'd0)
    else $error("next link without a valid link");

  // Block lookup results never mix with link results.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found_track != 6'd0 |->
      out_data.sectors_in_track == 5'd0 && out_data.block_number == 10'd0)
    else $error("block lookup item carries link fields");

endmodule

bind disk_zone_sector_mapper_core dzsm_check u_dzsm_check (.*);
